### sv/tekd_pkg.sv
// Package for the terminal escape key decoder.
// Holds the key kind codes, the item and result types and the sequence characters.
// No dependencies.
package tekd_pkg;

	typedef enum logic [3:0] {
		KIND_PLAIN = 4'd0,
		KIND_ESC   = 4'd1,
		KIND_UP    = 4'd2,
		KIND_DOWN  = 4'd3,
		KIND_RIGHT = 4'd4,
		KIND_LEFT  = 4'd5,
		KIND_HOME  = 4'd6,
		KIND_END   = 4'd7,
		KIND_DEL   = 4'd8,
		KIND_PGUP  = 4'd9,
		KIND_PGDN  = 4'd10,
		KIND_TABL  = 4'd11,
		KIND_TABR  = 4'd12
	} key_kind_t;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [7:0] CH_ESC     = 8'h1B;
	localparam logic [7:0] CH_BRACKET = 8'h5B;
	localparam logic [7:0] CH_O       = 8'h4F;
	localparam logic [7:0] CH_TILDE   = 8'h7E;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_FIVE    = 8'h35;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	typedef struct packed {
		logic       operation;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic       valid;
		key_kind_t  key_kind;
		logic [7:0] char_value;
	} result_t;

endpackage

### sv/tekd_parser.sv
// Escape sequence parser: state registers plus next-state and key decode logic.
// Uses tekd_pkg; stepped once per item by the top level.
module tekd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  tekd_pkg::item_t   item,
	output tekd_pkg::result_t result
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_ESC   = 3'd1,
		ST_LEAD  = 3'd2,
		ST_DIGIT = 3'd3,
		ST_SEMI  = 3'd4,
		ST_MOD   = 3'd5
	} stage_t;

	stage_t     stage_q, stage_d;
	logic [7:0] lead_q, digit_q, mod_q;
	logic       load_lead, load_digit, load_mod;
	logic [7:0] b;

	assign b = item.rx_byte;

	always_comb begin
		stage_d    = stage_q;
		load_lead  = 1'b0;
		load_digit = 1'b0;
		load_mod   = 1'b0;
		result     = '{valid: 1'b0, key_kind: tekd_pkg::KIND_PLAIN, char_value: 8'd0};
		if (item.operation == tekd_pkg::OP_TICK) begin
			if (stage_q inside {ST_ESC, ST_LEAD, ST_DIGIT, ST_SEMI, ST_MOD}) begin
				stage_d      = ST_IDLE;
				result.valid = 1'b1;
				result.key_kind = tekd_pkg::KIND_ESC;
			end
		end else begin
			case (stage_q)
				ST_ESC: begin
					load_lead = 1'b1;
					stage_d   = ST_LEAD;
				end
				ST_LEAD: begin
					if (lead_q == tekd_pkg::CH_BRACKET &&
					    b inside {[tekd_pkg::CH_ZERO:tekd_pkg::CH_NINE]}) begin
						load_digit = 1'b1;
						stage_d    = ST_DIGIT;
					end else begin
						stage_d         = ST_IDLE;
						result.valid    = 1'b1;
						result.key_kind = tekd_pkg::KIND_ESC;
						if (lead_q == tekd_pkg::CH_BRACKET) begin
							case (b)
								8'h41:   result.key_kind = tekd_pkg::KIND_UP;
								8'h42:   result.key_kind = tekd_pkg::KIND_DOWN;
								8'h43:   result.key_kind = tekd_pkg::KIND_RIGHT;
								8'h44:   result.key_kind = tekd_pkg::KIND_LEFT;
								8'h48:   result.key_kind = tekd_pkg::KIND_HOME;
								8'h46:   result.key_kind = tekd_pkg::KIND_END;
								default: result.key_kind = tekd_pkg::KIND_ESC;
							endcase
						end else if (lead_q == tekd_pkg::CH_O) begin
							case (b)
								8'h48:   result.key_kind = tekd_pkg::KIND_HOME;
								8'h46:   result.key_kind = tekd_pkg::KIND_END;
								default: result.key_kind = tekd_pkg::KIND_ESC;
							endcase
						end
					end
				end
				ST_DIGIT: begin
					if (b == tekd_pkg::CH_SEMI) begin
						stage_d = ST_SEMI;
					end else begin
						stage_d         = ST_IDLE;
						result.valid    = 1'b1;
						result.key_kind = tekd_pkg::KIND_ESC;
						if (b == tekd_pkg::CH_TILDE) begin
							case (digit_q)
								8'h31, 8'h37: result.key_kind = tekd_pkg::KIND_HOME;
								8'h33:        result.key_kind = tekd_pkg::KIND_DEL;
								8'h34, 8'h38: result.key_kind = tekd_pkg::KIND_END;
								8'h35:        result.key_kind = tekd_pkg::KIND_PGUP;
								8'h36:        result.key_kind = tekd_pkg::KIND_PGDN;
								default:      result.key_kind = tekd_pkg::KIND_ESC;
							endcase
						end
					end
				end
				ST_SEMI: begin
					load_mod = 1'b1;
					stage_d  = ST_MOD;
				end
				ST_MOD: begin
					stage_d         = ST_IDLE;
					result.valid    = 1'b1;
					result.key_kind = tekd_pkg::KIND_ESC;
					if (mod_q == tekd_pkg::CH_FIVE) begin
						if (b == 8'h44)
							result.key_kind = tekd_pkg::KIND_TABL;
						else if (b == 8'h43)
							result.key_kind = tekd_pkg::KIND_TABR;
					end
				end
				default: begin
					// idle, and unused codes treated as idle
					if (b == tekd_pkg::CH_ESC) begin
						stage_d = ST_ESC;
					end else begin
						stage_d           = ST_IDLE;
						result.valid      = 1'b1;
						result.key_kind   = tekd_pkg::KIND_PLAIN;
						result.char_value = b;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_IDLE;
			lead_q  <= 8'd0;
			digit_q <= 8'd0;
			mod_q   <= 8'd0;
		end else if (step) begin
			stage_q <= stage_d;
			if (load_lead)
				lead_q <= b;
			if (load_digit)
				digit_q <= b;
			if (load_mod)
				mod_q <= b;
		end
	end

endmodule

### sv/terminal_escape_key_decoder_top.sv
// Terminal escape key decoder, top level: input register, parser, result register.
// Uses tekd_pkg and tekd_parser.
//
// Usage:
//   Slave stream carries one request per byte or timeout tick: tuser = operation
//   (0 byte, 1 read timeout), tdata = received byte. Master stream carries key
//   events: tuser = key kind, tdata = character (plain keys only, else zero).
//   A request yields zero or one key event; ESC and the middle bytes of a
//   sequence, and timeouts while idle, yield none.
//   A request sits in the input register, then its result moves to the result
//   register, from which it is presented as a valid key event.
//   Throughput: one request per cycle while s_tready stays high.
//   The parser state advances only when its item moves on, so it is the one
//   state register loop that sets the rate.
//   Stall: while a result waits on m_tready, one further request is held in the
//   input register; s_tready drops only when both are full and a result is due.
//   Reset: all valids cleared, parser back to idle.
module terminal_escape_key_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] rx_byte
	input  logic       s_tuser,  // [0] operation
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] char_value
	output logic [3:0] m_tuser   // [3:0] key_kind
);

	logic              valid_s1;
	tekd_pkg::item_t   item_s1;
	tekd_pkg::result_t res;
	logic              out_valid_q;
	logic [3:0]        kind_q;
	logic [7:0]        char_q;
	logic              advance;

	assign advance  = !out_valid_q || m_tready || !res.valid;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			item_s1 <= '{operation: s_tuser, rx_byte: s_tdata};
	end

	tekd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && advance),
		.item   (item_s1),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (!out_valid_q || m_tready)
			out_valid_q <= valid_s1 && res.valid;
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && res.valid && (!out_valid_q || m_tready)) begin
			kind_q <= res.key_kind;
			char_q <= res.char_value;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = char_q;
	assign m_tuser  = kind_q;

	a_char_plain_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != tekd_pkg::KIND_PLAIN |-> m_tdata == 8'd0)
		else $error("char_value set on a non-plain key");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= tekd_pkg::KIND_TABR)
		else $error("key kind out of range");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("pending key event lost");

endmodule

### tb/sv/tb_terminal_escape_key_decoder_top.sv
`timescale 1ns / 1ps
// Testbench for terminal_escape_key_decoder_top: byte and timeout requests in,
// key events out, checked against an in-bench parser model. Uses tekd_pkg.
module tb_terminal_escape_key_decoder_top;

	localparam int LIMIT_CYCLES = 200000;
	localparam int MAX_IDLE     = 13;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_ESC   = 3'd1,
		ST_LEAD  = 3'd2,
		ST_DIGIT = 3'd3,
		ST_SEMI  = 3'd4,
		ST_MOD   = 3'd5
	} parse_stage_t;

	typedef struct {
		tekd_pkg::key_kind_t kind;
		logic [7:0]          value;
	} key_event_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tuser;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic [3:0] m_tuser;

	key_event_t   pending_keys[$];
	parse_stage_t stage;
	logic [7:0]   lead_q;
	logic [7:0]   digit_q;
	logic [7:0]   modifier_q;
	int           mismatches;
	int           requests_sent;
	int           rx_stall;
	int           hold_off;
	int           cycle_count;
	bit           idle_on;

	terminal_escape_key_decoder_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// parser model: advances on each accepted request, queues the key it yields
	task automatic predict_key(input logic op, input logic [7:0] b);
		key_event_t ev;
		logic       fire;
		fire     = 1'b1;
		ev.kind  = tekd_pkg::KIND_ESC;
		ev.value = 8'h00;
		if (op == tekd_pkg::OP_TICK) begin
			if (stage == ST_IDLE)
				fire = 1'b0;
			else
				stage = ST_IDLE;
		end else begin
			case (stage)
				ST_ESC: begin
					lead_q = b;
					stage  = ST_LEAD;
					fire   = 1'b0;
				end
				ST_LEAD: begin
					if (lead_q == tekd_pkg::CH_BRACKET && b >= tekd_pkg::CH_ZERO &&
					    b <= tekd_pkg::CH_NINE) begin
						digit_q = b;
						stage   = ST_DIGIT;
						fire    = 1'b0;
					end else begin
						if (lead_q == tekd_pkg::CH_BRACKET) begin
							case (b)
								"A": ev.kind = tekd_pkg::KIND_UP;
								"B": ev.kind = tekd_pkg::KIND_DOWN;
								"C": ev.kind = tekd_pkg::KIND_RIGHT;
								"D": ev.kind = tekd_pkg::KIND_LEFT;
								"H": ev.kind = tekd_pkg::KIND_HOME;
								"F": ev.kind = tekd_pkg::KIND_END;
								default: ev.kind = tekd_pkg::KIND_ESC;
							endcase
						end else if (lead_q == tekd_pkg::CH_O) begin
							if (b == "H")
								ev.kind = tekd_pkg::KIND_HOME;
							else if (b == "F")
								ev.kind = tekd_pkg::KIND_END;
						end
						stage = ST_IDLE;
					end
				end
				ST_DIGIT: begin
					if (b == tekd_pkg::CH_SEMI) begin
						stage = ST_SEMI;
						fire  = 1'b0;
					end else begin
						if (b == tekd_pkg::CH_TILDE) begin
							case (digit_q)
								"1", "7": ev.kind = tekd_pkg::KIND_HOME;
								"3":      ev.kind = tekd_pkg::KIND_DEL;
								"4", "8": ev.kind = tekd_pkg::KIND_END;
								"5":      ev.kind = tekd_pkg::KIND_PGUP;
								"6":      ev.kind = tekd_pkg::KIND_PGDN;
								default:  ev.kind = tekd_pkg::KIND_ESC;
							endcase
						end
						stage = ST_IDLE;
					end
				end
				ST_SEMI: begin
					modifier_q = b;
					stage      = ST_MOD;
					fire       = 1'b0;
				end
				ST_MOD: begin
					if (modifier_q == tekd_pkg::CH_FIVE && b == "D")
						ev.kind = tekd_pkg::KIND_TABL;
					else if (modifier_q == tekd_pkg::CH_FIVE && b == "C")
						ev.kind = tekd_pkg::KIND_TABR;
					stage = ST_IDLE;
				end
				default: begin
					if (b == tekd_pkg::CH_ESC) begin
						stage = ST_ESC;
						fire  = 1'b0;
					end else begin
						ev.kind  = tekd_pkg::KIND_PLAIN;
						ev.value = b;
						stage    = ST_IDLE;
					end
				end
			endcase
		end
		if (fire)
			pending_keys.push_back(ev);
	endtask

	// called and returns at a falling edge
	task automatic send_request(input logic op, input logic [7:0] b);
		int gap;
		gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		s_tvalid = 1'b0;
		repeat (gap) @(negedge clk);
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = b;
		do
			@(posedge clk);
		while (!s_tready);
		predict_key(op, b);
		requests_sent++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_request(tekd_pkg::OP_BYTE, b);
	endtask

	task automatic send_tick();
		logic [7:0] junk;
		junk = 8'($urandom_range(0, 255));
		send_request(tekd_pkg::OP_TICK, junk);
	endtask

	function automatic logic [7:0] mostly(input logic [7:0] want);
		logic [7:0] any;
		any = 8'($urandom_range(0, 255));
		return ($urandom_range(0, 4) == 0) ? any : want;
	endfunction

	function automatic logic [7:0] bracket_final();
		case ($urandom_range(0, 5))
			0: return "A";
			1: return "B";
			2: return "C";
			3: return "D";
			4: return "H";
			default: return "F";
		endcase
	endfunction

	task automatic send_random_key();
		logic [7:0] prefix [5];
		logic [7:0] digit;
		int         n;
		digit     = tekd_pkg::CH_ZERO + 8'($urandom_range(0, 9));
		prefix[0] = tekd_pkg::CH_ESC;
		prefix[1] = tekd_pkg::CH_BRACKET;
		prefix[2] = digit;
		prefix[3] = tekd_pkg::CH_SEMI;
		prefix[4] = tekd_pkg::CH_FIVE;
		case ($urandom_range(0, 9))
			0, 1: send_byte(8'($urandom_range(0, 255)));
			2: begin
				send_byte(tekd_pkg::CH_ESC);
				send_byte(tekd_pkg::CH_BRACKET);
				send_byte(mostly(bracket_final()));
			end
			3: begin
				send_byte(tekd_pkg::CH_ESC);
				send_byte(tekd_pkg::CH_O);
				send_byte(mostly($urandom_range(0, 1) ? "H" : "F"));
			end
			4: begin
				send_byte(tekd_pkg::CH_ESC);
				send_byte(tekd_pkg::CH_BRACKET);
				send_byte(digit);
				send_byte(mostly(tekd_pkg::CH_TILDE));
			end
			5: begin
				send_byte(tekd_pkg::CH_ESC);
				send_byte(tekd_pkg::CH_BRACKET);
				send_byte(digit);
				send_byte(tekd_pkg::CH_SEMI);
				send_byte(mostly(tekd_pkg::CH_FIVE));
				send_byte(mostly($urandom_range(0, 1) ? "D" : "C"));
			end
			6: begin
				send_byte(tekd_pkg::CH_ESC);
				send_byte(mostly(tekd_pkg::CH_ESC));
				send_byte(8'($urandom_range(0, 255)));
			end
			7: send_tick();
			8: begin
				// sequence cut short by a timeout
				n = $urandom_range(1, 5);
				for (int i = 0; i < n; i++)
					send_byte(prefix[i]);
				send_tick();
			end
			default: begin
				if ($urandom_range(0, 1))
					send_tick();
				else
					send_byte(8'($urandom_range(0, 255)));
			end
		endcase
	endtask

	task automatic test_directed();
		idle_on = 1'b1;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_tick();
		send_byte(tekd_pkg::CH_ESC); send_byte(tekd_pkg::CH_BRACKET); send_byte("A");
		send_byte(tekd_pkg::CH_ESC); send_byte(tekd_pkg::CH_O); send_byte("F");
		send_byte(tekd_pkg::CH_ESC); send_byte(tekd_pkg::CH_BRACKET); send_byte("5");
		send_byte(tekd_pkg::CH_TILDE);
		// digit followed by neither tilde nor semicolon
		send_byte(tekd_pkg::CH_ESC); send_byte(tekd_pkg::CH_BRACKET); send_byte("3");
		send_byte("x");
		send_byte(tekd_pkg::CH_ESC); send_byte(tekd_pkg::CH_BRACKET); send_byte("1");
		send_byte(tekd_pkg::CH_SEMI);
		send_byte(tekd_pkg::CH_FIVE); send_byte("C");
		send_byte(tekd_pkg::CH_ESC); send_byte("Z"); send_byte("Q");
		// ESC inside a sequence is just a sequence byte
		send_byte(tekd_pkg::CH_ESC); send_byte(tekd_pkg::CH_ESC);
		send_byte(tekd_pkg::CH_BRACKET);
		send_byte(tekd_pkg::CH_ESC); send_byte(tekd_pkg::CH_BRACKET); send_tick();
	endtask

	task automatic test_random_keys();
		idle_on = 1'b1;
		while (requests_sent < 160)
			send_random_key();
		idle_on = 1'b0;
		while (requests_sent < 220)
			send_random_key();
		idle_on = 1'b1;
		while (requests_sent < 300)
			send_random_key();
	endtask

	// receiver stops for a long stretch while requests keep coming
	task automatic test_backpressure();
		idle_on = 1'b0;
		@(posedge clk);
		hold_off = 120;
		@(negedge clk);
		for (int i = 0; i < 40; i++)
			send_random_key();
		idle_on = 1'b1;
	endtask

	always @(negedge clk) begin
		if (hold_off > 0) begin
			m_tready = 1'b0;
			hold_off = hold_off - 1;
		end else if (rx_stall > 0) begin
			m_tready = 1'b0;
			rx_stall = rx_stall - 1;
		end else begin
			m_tready = 1'b1;
		end
	end

	always @(posedge clk) begin : check_key_event
		key_event_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_keys.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected key event: kind %0d char %h", m_tuser, m_tdata);
			end else begin
				want = pending_keys.pop_front();
				if (m_tuser !== want.kind || m_tdata !== want.value) begin
					mismatches++;
					if (mismatches <= 10)
						$display("key mismatch: expected kind %0d char %h, got kind %0d char %h",
							want.kind, want.value, m_tuser, m_tdata);
				end
			end
			rx_stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = 8'h00;
		s_tuser       = tekd_pkg::OP_BYTE;
		m_tready      = 1'b0;
		stage         = ST_IDLE;
		lead_q        = 8'h00;
		digit_q       = 8'h00;
		modifier_q    = 8'h00;
		mismatches    = 0;
		requests_sent = 0;
		rx_stall      = 0;
		hold_off      = 0;
		idle_on       = 1'b1;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_keys();
		test_backpressure();

		while (pending_keys.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatches == 0 && pending_keys.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
